[design/rtc_tc_pkg.sv]
// ----------------------------------------------------------------------------
// RTC tick compensator package
// Shared widths, register indexes, reset values and control bundles.
// ----------------------------------------------------------------------------
package rtc_tc_pkg;

   localparam int RegWidth  = 20;
   localparam int RtcWidth  = 64;
   localparam int TickWidth = 32;
   localparam int ProdWidth = 2 * RegWidth;
   // RTC counts per tick: floor(P / 1e6) stays below 2^21 for 20-bit registers
   localparam int PerTickWidth = 21;
   localparam int DivSteps     = RtcWidth;
   localparam int CntWidth     = $clog2(DivSteps);
   localparam int MulBits      = 20;
   localparam int IdxWidth     = 1;

   localparam logic [IdxWidth-1:0] RegIdxClkHz = 1'd0;
   localparam logic [IdxWidth-1:0] RegIdxUsec  = 1'd1;

   localparam logic [RegWidth-1:0] ClkHzReset  = 20'd32000;
   localparam logic [RegWidth-1:0] UsecReset   = 20'd10000;
   localparam logic [MulBits-1:0]  UsecPerSec  = 20'd1000000;

   typedef struct packed {
      logic load;
      logic step;
   } div_ctl_type;

   typedef struct packed {
      logic clear;
      logic step;
   } mac_ctl_type;

endpackage

[design/rtc_tc_if.sv]
// ----------------------------------------------------------------------------
// RTC tick compensator channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rtc_tc_req_if;
   logic                            valid;
   logic                            ready;
   logic                            mode;
   logic [rtc_tc_pkg::RtcWidth-1:0] rtc_now;

   modport source (output valid, output mode, output rtc_now, input ready);
   modport sink (input valid, input mode, input rtc_now, output ready);
endinterface

interface rtc_tc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [rtc_tc_pkg::TickWidth-1:0] ticks_due;
   logic                             resynced;

   modport source (output valid, output ticks_due, output resynced, input ready);
   modport sink (input valid, input ticks_due, input resynced, output ready);
endinterface

[design/rtc_tc_div.sv]
// ----------------------------------------------------------------------------
// RTC tick compensator divider
// Radix-2 restoring divider, one quotient bit per step, quotient shifted
// into the dividend register.
// ----------------------------------------------------------------------------
module rtc_tc_div (
   input  logic                               clock,
   input  rtc_tc_pkg::div_ctl_type            ctl,
   input  logic [rtc_tc_pkg::ProdWidth-1:0]   load_rem,
   input  logic [rtc_tc_pkg::RtcWidth-1:0]    load_dvd,
   input  logic [rtc_tc_pkg::ProdWidth-1:0]   divisor,
   output logic [rtc_tc_pkg::RtcWidth-1:0]    quot,
   output logic                               qbit
);

   logic [rtc_tc_pkg::ProdWidth-1:0] rem_ff, rem_in;
   logic [rtc_tc_pkg::RtcWidth-1:0]  dvd_ff, dvd_in;
   logic [rtc_tc_pkg::ProdWidth:0]   rem_sh;
   logic [rtc_tc_pkg::ProdWidth+1:0] sub;

   always_comb begin
      rem_sh = {rem_ff, dvd_ff[rtc_tc_pkg::RtcWidth-1]};
      sub    = {1'b0, rem_sh} - {2'b0, divisor};
      qbit   = ~sub[rtc_tc_pkg::ProdWidth+1];
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      if (ctl.load) begin
         rem_in = load_rem;
         dvd_in = load_dvd;
      end else if (ctl.step) begin
         // a zero divisor always subtracts, giving an all-ones quotient
         rem_in = qbit ? sub[rtc_tc_pkg::ProdWidth-1:0]
                       : rem_sh[rtc_tc_pkg::ProdWidth-1:0];
         dvd_in = {dvd_ff[rtc_tc_pkg::RtcWidth-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign quot = dvd_ff;

endmodule

[design/rtc_tc_mac.sv]
// ----------------------------------------------------------------------------
// RTC tick compensator serial multiplier
// Shift-and-add accumulator, one multiplier bit per step, MSB first,
// wrapping at 64 bits.
// ----------------------------------------------------------------------------
module rtc_tc_mac (
   input  logic                             clock,
   input  rtc_tc_pkg::mac_ctl_type          ctl,
   input  logic                             mul_bit,
   input  logic [rtc_tc_pkg::RtcWidth-1:0]  addend,
   output logic [rtc_tc_pkg::RtcWidth-1:0]  acc
);

   logic [rtc_tc_pkg::RtcWidth-1:0] acc_ff, acc_in;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.step) begin
         acc_in = {acc_ff[rtc_tc_pkg::RtcWidth-2:0], 1'b0}
                  + (mul_bit ? addend : '0);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

[design/rtc_tick_compensator.sv]
// Sequence: a tick word goes through load, the 21-step radix-2 divide for
//   counts per tick, rounding, the 64-step radix-2 divide and the final step
//   before the hold step; a resync word, a first reading or a reading that
//   went backwards goes directly to the hold step. A new word is taken only
//   in idle; a stalled response register holds the sequencer in its last step.
// Reset: clears the stored reading to zero, restores the register defaults and
//   empties the response register; no clearing pass is needed.
// ----------------------------------------------------------------------------
// RTC tick compensator
// Turns a free-running RTC reading into a count of due system ticks, with
// rounding and carry of the fractional remainder to the next interrupt.
// ----------------------------------------------------------------------------
module rtc_tick_compensator (
   input  logic                                 clock,
   input  logic                                 reset,
   rtc_tc_req_if.sink                           req_chan,
   rtc_tc_rsp_if.source                         rsp_chan,
   input  logic                                 csr_we,
   input  logic [rtc_tc_pkg::IdxWidth-1:0]      csr_index,
   input  logic [rtc_tc_pkg::RegWidth-1:0]      csr_wdata
);

   // sequencer codes
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StLoad = 3'd1;   // load divider with P / 1e6
   localparam logic [2:0] StDivT = 3'd2;   // counts per tick, diff * 1e6 alongside
   localparam logic [2:0] StAdd  = 3'd3;   // round and load numerator
   localparam logic [2:0] StDivQ = 3'd4;   // tick quotient, Q * T alongside
   localparam logic [2:0] StFin  = 3'd5;   // pick outcome, advance stored reading
   localparam logic [2:0] StHold = 3'd6;   // hand result to response register

   localparam int W  = rtc_tc_pkg::RtcWidth;
   localparam int PW = rtc_tc_pkg::ProdWidth;
   localparam int TW = rtc_tc_pkg::PerTickWidth;
   localparam int CW = rtc_tc_pkg::CntWidth;

   logic [2:0]                        state_ff, state_in;
   logic [CW-1:0]                     cnt_ff, cnt_in;
   logic [rtc_tc_pkg::RegWidth-1:0]   clk_hz_ff, clk_hz_in;
   logic [rtc_tc_pkg::RegWidth-1:0]   usec_ff, usec_in;
   logic [W-1:0]                      last_ff, last_in;
   logic [W-1:0]                      now_ff, now_in;
   logic [W-1:0]                      diff_ff, diff_in;
   logic [PW-1:0]                     prod_ff, prod_in;
   logic [TW-1:0]                     tick_ff, tick_in;
   logic [rtc_tc_pkg::TickWidth-1:0]  stg_ticks_ff, stg_ticks_in;
   logic                              stg_resync_ff, stg_resync_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [rtc_tc_pkg::TickWidth-1:0]  rsp_ticks_ff, rsp_ticks_in;
   logic                              rsp_resync_ff, rsp_resync_in;

   logic                              req_fire;
   logic                              rsp_free;
   rtc_tc_pkg::div_ctl_type           div_ctl;
   rtc_tc_pkg::mac_ctl_type           mac_ctl;
   logic [PW-1:0]                     div_load_rem;
   logic [W-1:0]                      div_load_dvd;
   logic [PW-1:0]                     div_divisor;
   logic [W-1:0]                      div_quot;
   logic                              div_qbit;
   logic                              mac_bit;
   logic [W-1:0]                      mac_addend;
   logic [W-1:0]                      mac_acc;
   logic [4:0]                        mul_idx;
   logic [rtc_tc_pkg::MulBits-1:0]    mul_word;

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == StIdle);

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.ticks_due = rsp_ticks_ff;
   assign rsp_chan.resynced  = rsp_resync_ff;

   // multiplier bits of 1e6, MSB first, one per step of the T division until all MulBits are used
   assign mul_idx  = 5'(rtc_tc_pkg::MulBits - 1) - cnt_ff[4:0];
   assign mul_word = rtc_tc_pkg::UsecPerSec >> mul_idx;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      clk_hz_in     = clk_hz_ff;
      usec_in       = usec_ff;
      last_in       = last_ff;
      now_in        = now_ff;
      diff_in       = diff_ff;
      prod_in       = prod_ff;
      tick_in       = tick_ff;
      stg_ticks_in  = stg_ticks_ff;
      stg_resync_in = stg_resync_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_ticks_in  = rsp_ticks_ff;
      rsp_resync_in = rsp_resync_ff;

      div_ctl      = '0;
      mac_ctl      = '0;
      div_load_rem = '0;
      div_load_dvd = '0;
      div_divisor  = prod_ff;
      mac_bit      = 1'b0;
      mac_addend   = diff_ff;

      // register writes must arrive only while idle; the block itself does not enforce it
      if (csr_we) begin
         unique case (csr_index)
            rtc_tc_pkg::RegIdxClkHz: clk_hz_in = csr_wdata;
            rtc_tc_pkg::RegIdxUsec:  usec_in   = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         StIdle: begin
            if (req_fire) begin
               now_in = req_chan.rtc_now;
               if (req_chan.mode) begin
                  // resync request: load the reading, no ticks
                  last_in       = req_chan.rtc_now;
                  stg_ticks_in  = '0;
                  stg_resync_in = 1'b1;
                  state_in      = StHold;
               end else if (last_ff == '0 || req_chan.rtc_now < last_ff) begin
                  // first reading or counter went backwards: resync, one tick
                  last_in       = req_chan.rtc_now;
                  stg_ticks_in  = rtc_tc_pkg::TickWidth'(1);
                  stg_resync_in = 1'b1;
                  state_in      = StHold;
               end else begin
                  diff_in  = req_chan.rtc_now - last_ff;
                  prod_in  = {{(PW - rtc_tc_pkg::RegWidth){1'b0}}, clk_hz_ff}
                             * {{(PW - rtc_tc_pkg::RegWidth){1'b0}}, usec_ff};
                  state_in = StLoad;
               end
            end
         end
         StLoad: begin
            // P / 1e6 needs only TW quotient bits: preload the high part of P
            div_ctl.load = 1'b1;
            div_load_rem = PW'(prod_ff[PW-1:TW]);
            div_load_dvd = {prod_ff[TW-1:0], {(W - TW){1'b0}}};
            mac_ctl.clear = 1'b1;
            cnt_in   = '0;
            state_in = StDivT;
         end
         StDivT: begin
            div_ctl.step = 1'b1;
            div_divisor  = PW'(rtc_tc_pkg::UsecPerSec);
            mac_ctl.step = (cnt_ff < CW'(rtc_tc_pkg::MulBits));
            mac_bit      = mul_word[0];
            mac_addend   = diff_ff;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CW'(TW - 1)) begin
               state_in = StAdd;
            end
         end
         StAdd: begin
            // add half the counts per tick to round the quotient
            tick_in       = div_quot[TW-1:0];
            div_ctl.load  = 1'b1;
            div_load_rem  = '0;
            div_load_dvd  = mac_acc + W'(div_quot[TW-1:1]);
            mac_ctl.clear = 1'b1;
            cnt_in        = '0;
            state_in      = StDivQ;
         end
         StDivQ: begin
            // each quotient bit also drives the Q * T accumulator
            div_ctl.step = 1'b1;
            div_divisor  = prod_ff;
            mac_ctl.step = 1'b1;
            mac_bit      = div_qbit;
            mac_addend   = W'(tick_ff);
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CW'(rtc_tc_pkg::DivSteps - 1)) begin
               state_in = StFin;
            end
         end
         StFin: begin
            if (|div_quot[W-1:rtc_tc_pkg::TickWidth]) begin
               // too many ticks (or zero divisor): resync, one tick
               last_in       = now_ff;
               stg_ticks_in  = rtc_tc_pkg::TickWidth'(1);
               stg_resync_in = 1'b1;
            end else if (div_quot == '0) begin
               // never report zero ticks on an interrupt
               last_in       = last_ff + W'(tick_ff);
               stg_ticks_in  = rtc_tc_pkg::TickWidth'(1);
               stg_resync_in = 1'b0;
            end else begin
               // advance by whole ticks, keep the fraction for next time
               last_in       = last_ff + mac_acc;
               stg_ticks_in  = div_quot[rtc_tc_pkg::TickWidth-1:0];
               stg_resync_in = 1'b0;
            end
            state_in = StHold;
         end
         StHold: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_ticks_in  = stg_ticks_ff;
               rsp_resync_in = stg_resync_ff;
               state_in      = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         clk_hz_ff    <= rtc_tc_pkg::ClkHzReset;
         usec_ff      <= rtc_tc_pkg::UsecReset;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clk_hz_ff    <= clk_hz_in;
         usec_ff      <= usec_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      now_ff        <= now_in;
      diff_ff       <= diff_in;
      prod_ff       <= prod_in;
      tick_ff       <= tick_in;
      stg_ticks_ff  <= stg_ticks_in;
      stg_resync_ff <= stg_resync_in;
      rsp_ticks_ff  <= rsp_ticks_in;
      rsp_resync_ff <= rsp_resync_in;
   end

   rtc_tc_div u_div (
      .clock    (clock),
      .ctl      (div_ctl),
      .load_rem (div_load_rem),
      .load_dvd (div_load_dvd),
      .divisor  (div_divisor),
      .quot     (div_quot),
      .qbit     (div_qbit)
   );

   rtc_tc_mac u_mac (
      .clock   (clock),
      .ctl     (mac_ctl),
      .mul_bit (mac_bit),
      .addend  (mac_addend),
      .acc     (mac_acc)
   );

   // a result without resync always carries at least one tick
   a_ticks_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.resynced |-> rsp_chan.ticks_due != '0)
      else $error("tick result with zero ticks");

   // a resync request stages zero ticks with the resync flag
   a_resync_stage: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.mode |=> state_ff == StHold && stg_ticks_ff == '0
                                    && stg_resync_ff)
      else $error("resync request staged wrongly");

   // the stored reading moves only on acceptance or at the final step
   a_last_moves: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(last_ff)
         |-> $past(state_ff) == StIdle || $past(state_ff) == StFin)
      else $error("stored reading changed mid-computation");

   // no new word is taken during the tick quotient divide
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      state_ff == StDivQ |-> !req_chan.ready)
      else $error("request taken during divide");

endmodule
